[rtl/tcfa_pkg.sv]
// tcfa_pkg: shared types, codes and constants of the frame acceptance block
// used by tcfa_cfg_regs, tcfa_step and tc_frame_acceptance_farm; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcfa_pkg;

  localparam int unsigned MaxFrameBytes   = 1024;
  localparam int unsigned HeaderBytes     = 5;
  localparam int unsigned EcfBytes        = 2;
  localparam int unsigned UnlockDataBytes = 1;
  localparam int unsigned SetVrDataBytes  = 3;

  localparam int unsigned LenW      = 11;
  localparam int unsigned SeqW      = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 24;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_POS_WIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NEG_WIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ECF       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UNLOCK    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SETVR_B0  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SETVR_B1  = 3'd5;

  // service types
  localparam logic [1:0] ST_AD    = 2'd0;
  localparam logic [1:0] ST_BD    = 2'd1;
  localparam logic [1:0] ST_BC    = 2'd2;
  localparam logic [1:0] ST_OTHER = 2'd3;

  // frame actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_AD      = 2'd1;
  localparam logic [1:0] ACT_BD      = 2'd2;
  localparam logic [1:0] ACT_DISCARD = 2'd3;

  // reported mode codes
  localparam logic [1:0] MODE_CODE_OPEN = 2'd0;
  localparam logic [1:0] MODE_CODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_CODE_LOCK = 2'd2;

  // event codes
  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_AD_ACCEPT     = 4'd1;
  localparam logic [3:0] EV_AD_NO_BUFFER  = 4'd2;
  localparam logic [3:0] EV_AD_POS_WIN    = 4'd3;
  localparam logic [3:0] EV_AD_NEG_WIN    = 4'd4;
  localparam logic [3:0] EV_AD_LOCKOUT    = 4'd5;
  localparam logic [3:0] EV_BD_ACCEPT     = 4'd6;
  localparam logic [3:0] EV_UNLOCK        = 4'd7;
  localparam logic [3:0] EV_SET_VR        = 4'd8;
  localparam logic [3:0] EV_INVALID       = 4'd9;
  localparam logic [3:0] EV_BUFFER_FREE   = 4'd10;
  localparam logic [3:0] EV_REPORT        = 4'd11;

  typedef enum logic [2:0] {
    MODE_OPEN = 3'b001,
    MODE_WAIT = 3'b010,
    MODE_LOCK = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0] pos_win;
    logic [7:0] neg_win;
    logic       ecf_present;
    logic [7:0] unlock_octet;
    logic [7:0] setvr_b0;
    logic [7:0] setvr_b1;
  } cfg_t;

  typedef struct packed {
    mode_e           mode;
    logic [SeqW-1:0] vr;
    logic            lockout;
    logic            wait_flag;
    logic            retransmit;
    logic [1:0]      bcount;
  } farm_state_t;

  typedef struct packed {
    logic            report_due;
    logic            buf_full;
    logic            present;
    logic [1:0]      stype;
    logic [SeqW-1:0] ns;
    logic [LenW-1:0] len;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
  } frame_in_t;

  typedef struct packed {
    logic [1:0] action;
    logic       consumed;
    logic [3:0] event_code;
    logic       bad;
    logic       report;
  } step_res_t;

endpackage

`default_nettype wire

[rtl/tcfa_cfg_regs.sv]
// tcfa_cfg_regs: configuration register bank with a plain write port
// depends on tcfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcfa_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tcfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  output tcfa_pkg::cfg_t                     cfg_o
);
  import tcfa_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_WIN:  cfg_d.pos_win      = cfg_wdata_i;
        REG_NEG_WIN:  cfg_d.neg_win      = cfg_wdata_i;
        REG_ECF:      cfg_d.ecf_present  = cfg_wdata_i[0];
        REG_UNLOCK:   cfg_d.unlock_octet = cfg_wdata_i;
        REG_SETVR_B0: cfg_d.setvr_b0     = cfg_wdata_i;
        REG_SETVR_B1: cfg_d.setvr_b1     = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_win      <= 8'd5;
      cfg_q.neg_win      <= 8'd5;
      cfg_q.ecf_present  <= 1'b1;
      cfg_q.unlock_octet <= 8'd0;
      cfg_q.setvr_b0     <= 8'd130;
      cfg_q.setvr_b1     <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/tcfa_step.sv]
// tcfa_step: combinational next-state and result logic for one word
// depends on tcfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcfa_step (
  input  wire tcfa_pkg::cfg_t        cfg_i,
  input  wire tcfa_pkg::farm_state_t st_i,
  input  wire tcfa_pkg::frame_in_t   frm_i,
  output tcfa_pkg::farm_state_t      st_o,
  output tcfa_pkg::step_res_t        res_o
);
  import tcfa_pkg::*;

  logic [SeqW-1:0] ahead, behind;
  logic            in_pos, in_neg;
  logic [LenW-1:0] base_len;
  logic            len_fits, is_unlock, is_setvr;

  // modulo 256 distances from v(r)
  assign ahead  = frm_i.ns - st_i.vr;
  assign behind = st_i.vr - frm_i.ns;
  assign in_pos = ahead < cfg_i.pos_win;
  assign in_neg = (behind != '0) && (behind < cfg_i.neg_win);

  assign base_len = LenW'(HeaderBytes) + (cfg_i.ecf_present ? LenW'(EcfBytes) : '0);
  assign len_fits = frm_i.len <= LenW'(MaxFrameBytes);
  assign is_unlock = len_fits && (frm_i.len == base_len + LenW'(UnlockDataBytes))
                     && (frm_i.b0 == cfg_i.unlock_octet);
  assign is_setvr  = len_fits && (frm_i.len == base_len + LenW'(SetVrDataBytes))
                     && (frm_i.b0 == cfg_i.setvr_b0) && (frm_i.b1 == cfg_i.setvr_b1);

  always_comb begin
    st_o  = st_i;
    res_o = '{action: ACT_NONE, consumed: 1'b0, event_code: EV_NONE,
              bad: 1'b0, report: 1'b0};
    priority if (frm_i.report_due) begin
      res_o.event_code = EV_REPORT;
      res_o.report     = 1'b1;
    end else if (!frm_i.buf_full && st_i.wait_flag) begin
      res_o.event_code = EV_BUFFER_FREE;
      st_o.wait_flag   = 1'b0;
      if (st_i.mode == MODE_WAIT) st_o.mode = MODE_OPEN;
    end else if (frm_i.present) begin
      res_o.consumed = 1'b1;
      res_o.action   = ACT_DISCARD;
      unique case (frm_i.stype)
        ST_AD: begin
          priority if (frm_i.ns == st_i.vr) begin
            if (!frm_i.buf_full) begin
              res_o.event_code = EV_AD_ACCEPT;
              if (st_i.mode == MODE_OPEN) begin
                res_o.action    = ACT_AD;
                st_o.vr         = st_i.vr + SeqW'(1);
                st_o.retransmit = 1'b0;
              end else if (st_i.mode == MODE_WAIT) begin
                res_o.bad = 1'b1;
              end
            end else begin
              res_o.event_code = EV_AD_NO_BUFFER;
              if (st_i.mode == MODE_OPEN) begin
                st_o.retransmit = 1'b1;
                st_o.wait_flag  = 1'b1;
                st_o.mode       = MODE_WAIT;
              end
            end
          end else if (in_pos) begin
            res_o.event_code = EV_AD_POS_WIN;
            if (st_i.mode == MODE_OPEN) st_o.retransmit = 1'b1;
          end else if (in_neg) begin
            res_o.event_code = EV_AD_NEG_WIN;
          end else begin
            res_o.event_code = EV_AD_LOCKOUT;
            st_o.lockout     = 1'b1;
            st_o.mode        = MODE_LOCK;
          end
        end
        ST_BD: begin
          res_o.event_code = EV_BD_ACCEPT;
          res_o.action     = ACT_BD;
          st_o.bcount      = st_i.bcount + 2'd1;
        end
        ST_BC: begin
          priority if (is_unlock) begin
            res_o.event_code = EV_UNLOCK;
            st_o.bcount      = st_i.bcount + 2'd1;
            st_o.retransmit  = 1'b0;
            st_o.wait_flag   = 1'b0;
            st_o.lockout     = 1'b0;
            st_o.mode        = MODE_OPEN;
          end else if (is_setvr) begin
            res_o.event_code = EV_SET_VR;
            st_o.bcount      = st_i.bcount + 2'd1;
            // in lockout only the bypass counter moves
            if (st_i.mode != MODE_LOCK) begin
              st_o.retransmit = 1'b0;
              st_o.wait_flag  = 1'b0;
              st_o.vr         = frm_i.b2;
              st_o.mode       = MODE_OPEN;
            end
          end else begin
            res_o.event_code = EV_INVALID;
          end
        end
        ST_OTHER: res_o.event_code = EV_INVALID;
        default:  res_o.event_code = EV_INVALID;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/tc_frame_acceptance_farm.sv]
// tc_frame_acceptance_farm: cop-1 receiver frame acceptance, top level
// throughput: one word per cycle while the result stream is not stalled,
// set by the single state update in tcfa_step
// an input register and a result register separate the two stream sides
// reset: rst_ni asynchronous, clears control state to open mode, v(r) zero,
// flags and bypass counter zero, registers to their default values
`timescale 1ns / 1ps
`default_nettype none

module tc_frame_acceptance_farm (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [tcfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tcfa_pkg::CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // report_due, ad_buffer_full, frame_present, frame_seq[8], frame_length[11],
  // data_byte0[8], data_byte1[8], data_byte2[8], zero pad
  input  wire logic [tcfa_pkg::InDataW-1:0]  s_axis_tdata,
  // service_type[2]
  input  wire logic [1:0]                    s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // frame_action[2], frame_consumed, event_code[4], bad_combination, report_valid,
  // lockout_flag, wait_flag, retransmit_flag, bypass_count[2], report_vr[8],
  // farm_mode[2]
  output logic [tcfa_pkg::OutDataW-1:0]      m_axis_tdata
);
  import tcfa_pkg::*;

  cfg_t        cfg;
  farm_state_t st_q, st_d;
  frame_in_t   frm_q;
  step_res_t   res;
  logic        in_vld_q, out_vld_q, fire, in_take;
  logic [OutDataW-1:0] out_q, out_d;
  logic [1:0]  mode_code;

  tcfa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tcfa_step u_step (
    .cfg_i (cfg),
    .st_i  (st_q),
    .frm_i (frm_q),
    .st_o  (st_d),
    .res_o (res)
  );

  // a word leaves the input register when the result register has room
  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (st_d.mode)
      MODE_OPEN: mode_code = MODE_CODE_OPEN;
      MODE_WAIT: mode_code = MODE_CODE_WAIT;
      MODE_LOCK: mode_code = MODE_CODE_LOCK;
      default:   mode_code = MODE_CODE_OPEN;
    endcase
  end

  assign out_d = {mode_code, st_d.vr, st_d.bcount, st_d.retransmit, st_d.wait_flag,
                  st_d.lockout, res.report, res.bad, res.event_code, res.consumed,
                  res.action};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{mode: MODE_OPEN, vr: '0, lockout: 1'b0, wait_flag: 1'b0,
                     retransmit: 1'b0, bcount: '0};
    end else begin
      if (in_take)    in_vld_q <= 1'b1;
      else if (fire)  in_vld_q <= 1'b0;
      if (fire)                 out_vld_q <= 1'b1;
      else if (m_axis_tready)   out_vld_q <= 1'b0;
      if (fire) st_q <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frm_q.report_due <= s_axis_tdata[0];
      frm_q.buf_full   <= s_axis_tdata[1];
      frm_q.present    <= s_axis_tdata[2];
      frm_q.ns         <= s_axis_tdata[10:3];
      frm_q.len        <= s_axis_tdata[21:11];
      frm_q.b0         <= s_axis_tdata[29:22];
      frm_q.b1         <= s_axis_tdata[37:30];
      frm_q.b2         <= s_axis_tdata[45:38];
      frm_q.stype      <= s_axis_tuser;
    end
    if (fire) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

[sim/tc_frame_acceptance_farm_tb.sv]
// tc_frame_acceptance_farm_tb: self-checking bench for the cop-1 frame acceptance block
// drives frame words and register writes, predicts every result word and compares fields
// depends on rtl/tcfa_pkg.sv and rtl/tc_frame_acceptance_farm.sv
`timescale 1ns / 1ps

module tc_frame_acceptance_farm_tb;
  import tcfa_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned PendDepth  = 16;
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  // result word, msb first so that a cast from m_axis_tdata lines up
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] vr;
    logic [1:0] bcnt;
    logic       retx;
    logic       waitf;
    logic       lock;
    logic       rep;
    logic       bad;
    logic [3:0] ev;
    logic       cons;
    logic [1:0] act;
  } farm_word_t;

  typedef struct packed {
    frame_in_t  w;
    logic       typed;
    logic [3:0] ev;
    logic [1:0] act;
    logic       cons;
  } frame_row_t;

  typedef struct packed {
    logic [7:0]  pw;
    logic [7:0]  nw;
    logic [7:0]  ecf;
    logic [7:0]  ul;
    logic [7:0]  s0;
    logic [7:0]  s1;
    logic [11:0] count;
    logic        calm;
  } phase_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // predictor copy of the registers and the receiver state, at reset values
  logic [7:0] win_pos    = 8'd5;
  logic [7:0] win_neg    = 8'd5;
  logic       ecf_on     = 1'b1;
  logic [7:0] oct_unlock = 8'd0;
  logic [7:0] oct_set0   = 8'd130;
  logic [7:0] oct_set1   = 8'd0;
  logic [1:0] farm_mode  = MODE_CODE_OPEN;
  logic [7:0] seq_vr     = 8'd0;
  logic       flag_lock  = 1'b0;
  logic       flag_wait  = 1'b0;
  logic       flag_retx  = 1'b0;
  logic [1:0] bypass_cnt = 2'd0;

  // expected words in order, as a ring with free-running write and read counts
  farm_word_t  pending_words [PendDepth];
  int unsigned pend_wr     = 0;
  int unsigned pend_rd     = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  logic        steady      = 1'b0;

  // start under reset settings: window 5/5, error control on, unlock 0, set-v(r) 130 0
  frame_row_t dir_tbl [0:22] = '{
    '{'{1, 0, 1, ST_AD,    0,    0,   0,   0,   0}, 1, EV_REPORT,       ACT_NONE,    0},
    '{'{0, 0, 0, ST_AD,    0,    0,   0,   0,   0}, 1, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    0,    0,   0,   0,   0}, 1, EV_AD_ACCEPT,    ACT_AD,      1},
    '{'{0, 1, 1, ST_AD,    1,    0,   0,   0,   0}, 1, EV_AD_NO_BUFFER, ACT_DISCARD, 1},
    '{'{0, 1, 1, ST_AD,    1,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    1,    0,   0,   0,   0}, 1, EV_BUFFER_FREE,  ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    1,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    6,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    0,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    7,    0,   0,   0,   0}, 1, EV_AD_LOCKOUT,   ACT_DISCARD, 1},
    '{'{0, 0, 1, ST_AD,    2,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_BD,    0,    0,   0,   0,   0}, 1, EV_BD_ACCEPT,    ACT_BD,      1},
    '{'{0, 0, 1, ST_BC,    0,   10, 130,   0,  77}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_BC,    0,    8,   1,   0,   0}, 1, EV_INVALID,      ACT_DISCARD, 1},
    '{'{0, 0, 1, ST_BC,    0,    8,   0,   0,   0}, 1, EV_UNLOCK,       ACT_DISCARD, 1},
    '{'{0, 0, 1, ST_BC,    0,   10, 130,   0, 255}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,  255,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{0, 0, 1, ST_BC,    0, 2047,   0,   0,   0}, 1, EV_INVALID,      ACT_DISCARD, 1},
    '{'{0, 0, 1, ST_BC,    0,    0,   0,   0,   0}, 1, EV_INVALID,      ACT_DISCARD, 1},
    '{'{0, 0, 1, ST_OTHER, 0,    0,   0,   0,   0}, 1, EV_INVALID,      ACT_DISCARD, 1},
    '{'{0, 1, 1, ST_BD,  255, 2047, 255, 255, 255}, 0, EV_NONE,         ACT_NONE,    0},
    '{'{1, 1, 1, ST_OTHER, 255, 2047, 255, 255, 255}, 1, EV_REPORT,     ACT_NONE,    0},
    '{'{0, 0, 1, ST_AD,    4,    0,   0,   0,   0}, 0, EV_NONE,         ACT_NONE,    0}
  };

  // register settings per phase, window and octet extremes first
  phase_t phase_tbl [0:4] = '{
    '{8'd1,   8'd1,   8'hFE, 8'hFF, 8'h00, 8'hFF, 12'd230, 1'b0},
    '{8'd254, 8'd254, 8'h01, 8'h00, 8'hFF, 8'h00, 12'd230, 1'b0},
    '{8'd0,   8'd0,   8'hFF, 8'hA5, 8'h5A, 8'hC3, 12'd230, 1'b0},
    '{8'd255, 8'd255, 8'h80, 8'h3C, 8'h82, 8'h00, 12'd230, 1'b1},
    '{8'd5,   8'd5,   8'h01, 8'h00, 8'd130, 8'h00, 12'd230, 1'b0}
  };

  tc_frame_acceptance_farm DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tc_frame_acceptance_farm_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 22);
  end

  function automatic logic [InDataW-1:0] pack_frame(input frame_in_t w);
    return {2'b00, w.b2, w.b1, w.b0, w.len, w.ns, w.present, w.buf_full, w.report_due};
  endfunction

  // one step of the receiver: updates the predictor state, returns the result word
  task automatic farm_predict(input frame_in_t w, output farm_word_t r);
    logic [7:0]  ahead;
    logic [7:0]  behind;
    int unsigned base;
    r = '0;
    base = HeaderBytes + (ecf_on ? EcfBytes : 0);
    if (w.report_due) begin
      r.ev  = EV_REPORT;
      r.rep = 1'b1;
    end else if (!w.buf_full && flag_wait) begin
      r.ev = EV_BUFFER_FREE;
      flag_wait = 1'b0;
      if (farm_mode == MODE_CODE_WAIT) farm_mode = MODE_CODE_OPEN;
    end else if (w.present) begin
      r.cons = 1'b1;
      r.act  = ACT_DISCARD;
      case (w.stype)
        ST_AD: begin
          if (w.ns == seq_vr) begin
            if (!w.buf_full) begin
              r.ev = EV_AD_ACCEPT;
              if (farm_mode == MODE_CODE_OPEN) begin
                r.act     = ACT_AD;
                seq_vr    = seq_vr + 8'd1;
                flag_retx = 1'b0;
              end else if (farm_mode == MODE_CODE_WAIT) begin
                r.bad = 1'b1;
              end
            end else begin
              r.ev = EV_AD_NO_BUFFER;
              if (farm_mode == MODE_CODE_OPEN) begin
                flag_retx = 1'b1;
                flag_wait = 1'b1;
                farm_mode = MODE_CODE_WAIT;
              end
            end
          end else begin
            ahead  = w.ns - seq_vr;
            behind = seq_vr - w.ns;
            // positive window is tried first where the two overlap
            if (ahead < win_pos) begin
              r.ev = EV_AD_POS_WIN;
              if (farm_mode == MODE_CODE_OPEN) flag_retx = 1'b1;
            end else if (behind >= 8'd1 && behind < win_neg) begin
              r.ev = EV_AD_NEG_WIN;
            end else begin
              r.ev      = EV_AD_LOCKOUT;
              flag_lock = 1'b1;
              farm_mode = MODE_CODE_LOCK;
            end
          end
        end
        ST_BD: begin
          r.ev       = EV_BD_ACCEPT;
          r.act      = ACT_BD;
          bypass_cnt = bypass_cnt + 2'd1;
        end
        ST_BC: begin
          if (w.len <= MaxFrameBytes && w.len == base + UnlockDataBytes && w.b0 == oct_unlock) begin
            r.ev       = EV_UNLOCK;
            bypass_cnt = bypass_cnt + 2'd1;
            flag_retx  = 1'b0;
            flag_wait  = 1'b0;
            flag_lock  = 1'b0;
            farm_mode  = MODE_CODE_OPEN;
          end else if (w.len <= MaxFrameBytes && w.len == base + SetVrDataBytes &&
                       w.b0 == oct_set0 && w.b1 == oct_set1) begin
            r.ev       = EV_SET_VR;
            bypass_cnt = bypass_cnt + 2'd1;
            // in lockout only the bypass counter moves
            if (farm_mode != MODE_CODE_LOCK) begin
              flag_retx = 1'b0;
              flag_wait = 1'b0;
              seq_vr    = w.b2;
              farm_mode = MODE_CODE_OPEN;
            end
          end else begin
            r.ev = EV_INVALID;
          end
        end
        default: r.ev = EV_INVALID;
      endcase
    end
    r.lock  = flag_lock;
    r.waitf = flag_wait;
    r.retx  = flag_retx;
    r.bcnt  = bypass_cnt;
    r.vr    = seq_vr;
    r.mode  = farm_mode;
  endtask

  // mostly well-formed frames aimed at v(r), the windows and the two commands
  function automatic frame_in_t next_frame();
    frame_in_t   w;
    int unsigned base;
    int unsigned pick;
    base         = HeaderBytes + (ecf_on ? EcfBytes : 0);
    w.report_due = ($urandom_range(99) < 5);
    w.buf_full   = ($urandom_range(99) < 15);
    w.present    = ($urandom_range(99) < 94);
    w.stype      = ST_OTHER;
    w.ns         = 8'($urandom);
    w.len        = 11'($urandom_range(MaxFrameBytes));
    w.b0         = 8'($urandom);
    w.b1         = 8'($urandom);
    w.b2         = 8'($urandom);
    pick         = $urandom_range(99);
    if (pick < 8) begin
      {w.report_due, w.buf_full, w.present, w.stype} = 5'($urandom);
      w.len = 11'($urandom);
    end else if (pick < 58) begin
      w.stype = ST_AD;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: w.ns = seq_vr;
        5, 6:          w.ns = seq_vr + 8'($urandom_range(win_pos));
        7, 8:          w.ns = seq_vr - 8'($urandom_range(win_neg));
        default: ;
      endcase
    end else if (pick < 68) begin
      w.stype = ST_BD;
    end else if (pick < 92) begin
      w.stype = ST_BC;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          w.len = 11'(base + UnlockDataBytes);
          w.b0  = oct_unlock;
        end
        4, 5, 6, 7: begin
          w.len = 11'(base + SetVrDataBytes);
          w.b0  = oct_set0;
          w.b1  = oct_set1;
        end
        default: w.len = 11'($urandom_range(12));
      endcase
    end
    return w;
  endfunction

  task automatic send_frame(input frame_in_t w, input logic typed, input logic [3:0] ev,
                            input logic [1:0] act, input logic cons);
    farm_word_t want;
    while (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_frame(w);
    s_axis_tuser  <= w.stype;
    do @(posedge clk_i); while (!s_axis_tready);
    farm_predict(w, want);
    if (typed) begin
      want.ev   = ev;
      want.act  = act;
      want.cons = cons;
    end
    pending_words[pend_wr % PendDepth] = want;
    pend_wr++;
  endtask

  task automatic write_settings(input logic [7:0] pw, nw, ecf, ul, s0, s1);
    logic [CfgIdxW-1:0] idx [8];
    logic [7:0]         val [8];
    idx = '{REG_SPARE_A, REG_POS_WIN, REG_NEG_WIN, REG_ECF, REG_UNLOCK, REG_SETVR_B0,
            REG_SETVR_B1, REG_SPARE_B};
    val = '{8'($urandom), pw, nw, ecf, ul, s0, s1, 8'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        REG_POS_WIN:  win_pos    = val[i];
        REG_NEG_WIN:  win_neg    = val[i];
        REG_ECF:      ecf_on     = val[i][0];
        REG_UNLOCK:   oct_unlock = val[i];
        REG_SETVR_B0: oct_set0   = val[i];
        REG_SETVR_B1: oct_set1   = val[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle(input int unsigned extra);
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    farm_word_t want;
    farm_word_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = farm_word_t'(m_axis_tdata);
      if (pend_wr == pend_rd) begin
        $display("%0t: result word with none expected, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_words[pend_rd % PendDepth];
        pend_rd++;
        check_field("frame_action", want.act, got.act);
        check_field("frame_consumed", want.cons, got.cons);
        check_field("event_code", want.ev, got.ev);
        check_field("bad_combination", want.bad, got.bad);
        check_field("report_valid", want.rep, got.rep);
        check_field("lockout_flag", want.lock, got.lock);
        check_field("wait_flag", want.waitf, got.waitf);
        check_field("retransmit_flag", want.retx, got.retx);
        check_field("bypass_count", want.bcnt, got.bcnt);
        check_field("report_vr", want.vr, got.vr);
        check_field("farm_mode", want.mode, got.mode);
      end
    end
  end

  initial begin
    phase_t ph;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) begin
      send_frame(dir_tbl[i].w, dir_tbl[i].typed, dir_tbl[i].ev, dir_tbl[i].act,
                 dir_tbl[i].cons);
    end
    s_axis_tvalid <= 1'b0;
    // table phases, then two with random settings
    for (int p = 0; p < 7; p++) begin
      settle(4);
      if (p < 5) begin
        ph = phase_tbl[p];
      end else begin
        ph = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 12'd300, 1'b0};
      end
      write_settings(ph.pw, ph.nw, ph.ecf, ph.ul, ph.s0, ph.s1);
      steady = ph.calm;
      repeat (ph.count) send_frame(next_frame(), 1'b0, EV_NONE, ACT_NONE, 1'b0);
      s_axis_tvalid <= 1'b0;
      steady = 1'b0;
    end
    settle(10);
    if (mismatches == 0) begin
      $display("tc_frame_acceptance_farm_tb passed");
    end else begin
      $display("tc_frame_acceptance_farm_tb failed");
    end
    $finish;
  end

endmodule
